/* design/fpba_pkg.sv */
// Package for the fit-policy block allocator: sizes, codes, state and shared types.
package fpba_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

	localparam int SEL_W      = 4;
	localparam int AMOUNT_W   = 16;
	localparam int POLICY_W   = 2;
	localparam int BLOCKS_W   = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'd1;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	typedef enum logic [POLICY_W-1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2,
		POL_NEXT  = 2'd3
	} fit_policy_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_SCAN,
		ST_WRITE
	} fpba_state_t;

	typedef struct packed {
		logic                 fits;
		logic                 lt;
		logic                 gt;
		logic [SIZE_BITS-1:0] diff;
	} fpba_cmp_t;

endpackage

/* design/fpba_if.sv */
// Request and response channel interfaces of the fit-policy block allocator.
interface fpba_req_if
	import fpba_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                opcode;
	logic [SEL_W-1:0]    block_select;
	logic [AMOUNT_W-1:0] amount;

	modport source (output valid, output opcode, output block_select, output amount,
		input ready);
	modport sink (input valid, input opcode, input block_select, input amount,
		output ready);
endinterface

interface fpba_rsp_if
	import fpba_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                granted;
	logic [SEL_W-1:0]    chosen_block;
	logic [AMOUNT_W-1:0] remaining;

	modport source (output valid, output granted, output chosen_block, output remaining,
		input ready);
	modport sink (input valid, input granted, input chosen_block, input remaining,
		output ready);
endinterface

/* design/fpba_cap_file.sv */
// Capacity register file: one write port, one read port, cleared to zero at reset.
module fpba_cap_file
	import fpba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [IDX_W-1:0]     waddr,
	input  logic [SIZE_BITS-1:0] wdata,
	input  logic [IDX_W-1:0]     raddr,
	output logic [SIZE_BITS-1:0] rdata
);

	logic [SIZE_BITS-1:0] cap_q [MAX_BLOCKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				cap_q[i] <= '0;
			end
		end else if (we) begin
			cap_q[waddr] <= wdata;
		end
	end

	assign rdata = cap_q[raddr];

endmodule

/* design/fpba_cmp_unit.sv */
// Shared compare unit: fit test, rank compare and remaining capacity for one block.
module fpba_cmp_unit
	import fpba_pkg::*;
(
	input  logic [SIZE_BITS-1:0] cap,
	input  logic [SIZE_BITS-1:0] need,
	input  logic [SIZE_BITS-1:0] best,
	output fpba_cmp_t            res
);

	logic [SIZE_BITS:0] sub;

	assign sub      = {1'b0, cap} - {1'b0, need};
	assign res.fits = ~sub[SIZE_BITS];
	assign res.diff = sub[SIZE_BITS-1:0];
	assign res.lt   = cap < best;
	assign res.gt   = cap > best;

endmodule

/* design/fit_policy_block_allocator.sv */
// Top level of the fit-policy block allocator: sequencer, registers and assertions.
// A load request gives no response. In an allocate request the one compare unit examines
// one stored capacity per cycle over the n active blocks (at most MAX_BLOCKS), then the
// write-back state follows; best and worst fit always examine all n, first and next fit
// stop at the first fit. Under next fit, the pointer is first reduced modulo n.
// A request with a block count of zero is refused without a search. A new request is
// taken while a response still waits; the write-back waits for the response slot.
module fit_policy_block_allocator
	import fpba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	fpba_req_if.sink              req,
	fpba_rsp_if.source            rsp
);

	fit_policy_t           policy_q;
	logic [BLOCKS_W-1:0]   blocks_q;
	logic [IDX_W-1:0]      rotate_q;

	fpba_state_t           state_q, state_d;
	logic [SIZE_BITS-1:0]  need_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  have_q;
	logic [IDX_W-1:0]      pick_q;
	logic [SIZE_BITS-1:0]  pick_cap_q;
	logic [SIZE_BITS-1:0]  rem_q;

	logic                  out_valid_q;
	logic                  out_granted_q;
	logic [SEL_W-1:0]      out_block_q;
	logic [AMOUNT_W-1:0]   out_rem_q;

	logic                  req_fire;
	logic                  load_fire;
	logic                  alloc_fire;
	logic [CNT_W-1:0]      n_eff;
	logic                  mod_ge;
	logic                  take;
	logic                  scan_last;
	logic                  slot_free;
	logic                  wb_fire;
	logic [CNT_W-1:0]      cnt_inc;
	logic [CNT_W-1:0]      idx_inc;

	logic                  cf_we;
	logic [IDX_W-1:0]      cf_waddr;
	logic [SIZE_BITS-1:0]  cf_wdata;
	logic [SIZE_BITS-1:0]  cf_rdata;
	fpba_cmp_t             cmp;

	fpba_cap_file u_cap_file (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cf_we),
		.waddr (cf_waddr),
		.wdata (cf_wdata),
		.raddr (idx_q),
		.rdata (cf_rdata)
	);

	fpba_cmp_unit u_cmp_unit (
		.cap (cf_rdata),
		.need(need_q),
		.best(pick_cap_q),
		.res (cmp)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIRST;
			blocks_q <= BLOCKS_W'(MAX_BLOCKS);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIT_POLICY:    policy_q <= fit_policy_t'(cfg_wdata[POLICY_W-1:0]);
				REG_BLOCKS_IN_USE: blocks_q <= cfg_wdata[BLOCKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign req.ready  = (state_q == ST_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign load_fire  = req_fire && (req.opcode == OP_LOAD);
	assign alloc_fire = req_fire && (req.opcode == OP_ALLOC);

	assign n_eff = (int'(blocks_q) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : CNT_W'(blocks_q);

	assign mod_ge    = CNT_W'(idx_q) >= n_q;
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign idx_inc   = CNT_W'(idx_q) + CNT_W'(1);
	assign scan_last = (cnt_inc == n_q);
	assign slot_free = !out_valid_q || rsp.ready;
	assign wb_fire   = (state_q == ST_WRITE) && slot_free;

	always_comb begin
		case (policy_q)
			POL_BEST:  take = cmp.fits && (!have_q || cmp.lt);
			POL_WORST: take = cmp.fits && (!have_q || cmp.gt);
			default:   take = cmp.fits;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (alloc_fire) begin
					if (n_eff == '0) begin
						state_d = ST_WRITE;
					end else if (policy_q == POL_NEXT) begin
						state_d = ST_MOD;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_MOD: begin
				if (!mod_ge) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if ((take && (policy_q == POL_FIRST || policy_q == POL_NEXT)) || scan_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// capacity write port
	always_comb begin
		cf_we    = 1'b0;
		cf_waddr = pick_q;
		cf_wdata = rem_q;
		case (state_q)
			ST_IDLE: begin
				cf_we    = load_fire && (int'(req.block_select) < MAX_BLOCKS);
				cf_waddr = IDX_W'(req.block_select);
				cf_wdata = SIZE_BITS'(req.amount);
			end
			ST_WRITE: begin
				cf_we = wb_fire && have_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rotate_q <= '0;
			have_q   <= 1'b0;
			cnt_q    <= '0;
			idx_q    <= '0;
			n_q      <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (load_fire) begin
						rotate_q <= '0;
					end
					if (alloc_fire) begin
						n_q    <= n_eff;
						cnt_q  <= '0;
						have_q <= 1'b0;
						idx_q  <= (policy_q == POL_NEXT) ? rotate_q : '0;
					end
				end
				ST_MOD: begin
					if (mod_ge) begin
						idx_q <= IDX_W'(CNT_W'(idx_q) - n_q);
					end
				end
				ST_SCAN: begin
					if (take) begin
						have_q <= 1'b1;
					end
					cnt_q <= cnt_inc;
					idx_q <= (idx_inc == n_q) ? '0 : IDX_W'(idx_inc);
				end
				ST_WRITE: begin
					if (wb_fire && have_q && policy_q == POL_NEXT) begin
						rotate_q <= pick_q;
					end
				end
				default: ;
			endcase
		end
	end

	// search payload
	always_ff @(posedge clk) begin
		if (alloc_fire) begin
			need_q <= SIZE_BITS'(req.amount);
		end
		if (state_q == ST_SCAN && take) begin
			pick_q     <= idx_q;
			pick_cap_q <= cf_rdata;
			rem_q      <= cmp.diff;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_fire) begin
			out_granted_q <= have_q;
			out_block_q   <= have_q ? SEL_W'(pick_q) : '0;
			out_rem_q     <= have_q ? AMOUNT_W'(rem_q) : '0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.granted      = out_granted_q;
	assign rsp.chosen_block = out_block_q;
	assign rsp.remaining    = out_rem_q;

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q < n_q && CNT_W'(idx_q) < n_q))
		else $error("scan index beyond active block count");

	a_search_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD || state_q == ST_SCAN) |-> (n_q != '0))
		else $error("search running with no active blocks");

	a_rsp_from_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WRITE))
		else $error("response raised outside write-back");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.granted) |-> (rsp.chosen_block == '0 && rsp.remaining == '0))
		else $error("refused response carries nonzero fields");

endmodule
